// File: rtl/core/slrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrp_pkg: shared types and constants of the linear ramp planner
// Item structs, register indexes, phase codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package slrp_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_RATE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY_SCALE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SQRT_SCALE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_LENGTH_SCALE = 3'd6;

    // Register reset values
    localparam logic [15:0] RST_ACCEL_RATE        = 16'd800;
    localparam logic [15:0] RST_DECEL_RATE        = 16'd500;
    localparam logic [15:0] RST_MAX_SPEED         = 16'd5000;
    localparam logic [31:0] RST_MIN_DELAY_SCALE   = 32'd4342934;
    localparam logic [15:0] RST_FIRST_DELAY_SCALE = 16'd9345;
    localparam logic [31:0] RST_ACCEL_SQRT_SCALE  = 32'd628318530;
    localparam logic [15:0] RST_RAMP_LENGTH_SCALE = 16'd628;

    // Datapath constants
    localparam logic [31:0] ONE_STEP_DELAY = 32'd1000;
    localparam logic [31:0] PERCENT_DIV    = 32'd100;
    // x / 100 == (x * PCT_RECIP) >> PCT_SHIFT for any 32-bit x
    localparam logic [31:0] PCT_RECIP      = 32'h51EB_851F;
    localparam int          PCT_SHIFT      = 37;
    localparam logic [31:0] SQRT_TOP_BIT   = 32'h4000_0000;
    localparam int          DIV_STEPS      = 64;
    localparam int          DIV_CNT_W      = $clog2(DIV_STEPS + 1);

    // Ramp phase codes
    typedef enum logic [1:0] {
        PH_STOP  = 2'd0,
        PH_ACCEL = 2'd1,
        PH_DECEL = 2'd2,
        PH_RUN   = 2'd3
    } phase_t;

    // Input op codes
    localparam logic OP_MOVE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] target_position;
    } in_item_t;

    typedef struct packed {
        logic        step_pulse;
        logic        move_direction;
        logic [31:0] timer_match;
        logic        busy_res;
        logic [1:0]  ramp_phase;
        logic [31:0] position;
        logic        command_taken;
    } out_item_t;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        DP_NOP, DP_LOAD, DP_PLAN0, DP_MIND, DP_SQDIV, DP_SQRT, DP_MUL1,
        DP_FDIV, DP_MUL2, DP_DDIV, DP_MUL3, DP_TDIV, DP_MUL4, DP_LDIV,
        DP_DCLIM, DP_MUL5, DP_CDIV, DP_FIN, DP_TICK0, DP_RDIV, DP_OUT
    } dp_op_t;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_PLAN0, ST_MIND, ST_SQDIV, ST_SQRT, ST_MUL1,
        ST_FDIV, ST_MUL2, ST_DDIV, ST_MUL3, ST_TDIV, ST_MUL4, ST_LDIV,
        ST_CHK, ST_MUL5, ST_CDIV, ST_FIN, ST_TICK0, ST_RDIV, ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   div_start;
        logic   sqrt_start;
    } dp_cmd_t;

    typedef struct packed {
        logic   busy;
        logic   in_op;
        logic   short_move;
        phase_t phase;
        logic   div_done;
        logic   sqrt_done;
        logic   den_zero;
        logic   lim_le_top;
        logic   out_free;
    } dp_status_t;

endpackage

// File: rtl/core/slrp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrp_div: restoring divider, 64 by 32 bits
// One quotient bit per cycle; done pulses for one cycle with results held.
// ----------------------------------------------------------------------------
module slrp_div
    import slrp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [31:0] remainder
);

    logic                 active_reg, active_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0]          quo_reg, quo_next;
    logic [31:0]          rem_reg, rem_next;
    logic [31:0]          dvs_reg, dvs_next;
    logic [32:0]          trial;
    logic [32:0]          trial_sub;
    logic                 fits;

    // trial subtraction of one bit
    assign trial     = {rem_reg, quo_reg[63]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = (trial >= {1'b0, dvs_reg});

    always_comb begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        if (start) begin
            active_next = 1'b1;
            cnt_next    = DIV_CNT_W'(DIV_STEPS);
            quo_next    = dividend;
            rem_next    = '0;
            dvs_next    = divisor;
        end else if (active_reg) begin
            quo_next = {quo_reg[62:0], fits};
            rem_next = fits ? trial_sub[31:0] : trial[31:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // operands
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/slrp_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrp_sqrt: bitwise integer square root, rounded
// Two radicand bits per cycle; root rounded up when the remainder exceeds it.
// ----------------------------------------------------------------------------
module slrp_sqrt
    import slrp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] radicand,
    output logic        done,
    output logic [16:0] root
);

    logic        active_reg, active_next;
    logic        done_reg, done_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] bit_reg, bit_next;
    logic [32:0] sum;
    logic        take;
    logic [31:0] r_sh;

    assign sum  = {1'b0, r_reg} + {1'b0, bit_reg};
    assign take = (sum <= {1'b0, x_reg});
    assign r_sh = r_reg >> 1;

    always_comb begin
        active_next = active_reg;
        done_next   = 1'b0;
        x_next      = x_reg;
        r_next      = r_reg;
        bit_next    = bit_reg;
        if (start) begin
            active_next = 1'b1;
            x_next      = radicand;
            r_next      = '0;
            bit_next    = SQRT_TOP_BIT;
        end else if (active_reg) begin
            x_next   = take ? (x_reg - sum[31:0]) : x_reg;
            r_next   = take ? (r_sh + bit_reg) : r_sh;
            bit_next = bit_reg >> 2;
            if ((bit_reg >> 2) == 32'd0) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    // working values
    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    // root never exceeds 16 bits before rounding
    assign root = {1'b0, r_reg[15:0]} + 17'((r_reg < x_reg) ? 1 : 0);
    assign done = done_reg;

endmodule

// File: rtl/core/slrp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrp_datapath: planner registers, shared multiplier, divider and root
// Executes one micro-operation per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
module slrp_datapath
    import slrp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  in_item_t             s_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data
);

    // configuration
    logic [15:0] accel_rate_reg, decel_rate_reg, max_speed_reg;
    logic [31:0] min_delay_scale_reg, accel_sqrt_scale_reg;
    logic [15:0] first_delay_scale_reg, ramp_length_scale_reg;

    // move state
    phase_t      phase_reg, phase_next;
    logic        dir_reg, dir_next;
    logic        busy_reg, busy_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] sd_reg, sd_next;
    logic [31:0] mind_reg, mind_next;
    logic [31:0] rc_reg, rc_next;
    logic [31:0] dss_reg, dss_next;
    logic [31:0] dc_reg, dc_next;
    logic [31:0] steps_reg, steps_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] lad_reg, lad_next;

    // working values
    logic        in_op_reg, in_op_next;
    logic [31:0] tgt_reg, tgt_next;
    logic [31:0] shown_reg, shown_next;
    logic        pulse_reg, pulse_next;
    logic        taken_reg, taken_next;
    logic [31:0] mag_reg, mag_next;
    logic [31:0] sqin_reg, sqin_next;
    logic [16:0] root_reg, root_next;
    logic [47:0] prod_reg, prod_next;
    logic [31:0] den_reg, den_next;
    logic [31:0] top_reg, top_next;
    logic [31:0] lim_reg, lim_next;

    // result register
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg, m_data_next;

    logic [15:0] acc, dec, spd;
    logic [31:0] diff, diff_mag;
    logic [31:0] mul_a;
    logic [16:0] mul_b;
    logic [48:0] mul_full;
    logic [63:0] pct_prod;
    logic [31:0] pct_quo;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done, sqrt_done;
    logic [63:0] div_quo;
    logic [31:0] div_rem;
    logic [16:0] sqrt_root;
    logic [33:0] num_s, num_mag;
    logic [31:0] den_s, den_mag;
    logic        num_neg, den_neg;
    logic [31:0] q32, r32, rec_next;
    logic [31:0] dc_lim, dc_quo;
    logic [31:0] steps_inc;
    logic [31:0] rc_inc;
    logic        out_free;

    // rate registers of zero act as one
    assign acc = (accel_rate_reg == 16'd0) ? 16'd1 : accel_rate_reg;
    assign dec = (decel_rate_reg == 16'd0) ? 16'd1 : decel_rate_reg;
    assign spd = (max_speed_reg  == 16'd0) ? 16'd1 : max_speed_reg;

    // distance to target
    assign diff     = tgt_reg - pos_reg;
    assign diff_mag = diff[31] ? (32'd0 - diff) : diff;

    // shared multiplier operands
    always_comb begin
        case (cmd.op)
            DP_MUL1: begin mul_a = {16'd0, first_delay_scale_reg}; mul_b = root_reg;         end
            DP_MUL2: begin mul_a = {16'd0, ramp_length_scale_reg}; mul_b = {1'b0, acc};      end
            DP_MUL3: begin mul_a = {16'd0, spd};                   mul_b = {1'b0, spd};      end
            DP_MUL4: begin mul_a = mag_reg;                        mul_b = {1'b0, dec};      end
            DP_MUL5: begin mul_a = top_reg;                        mul_b = {1'b0, acc};      end
            default: begin mul_a = '0;                             mul_b = '0;               end
        endcase
    end
    assign mul_full = mul_a * mul_b;

    // divide by 100 through the reciprocal; both products fit 32 bits
    assign pct_prod = {32'd0, prod_reg[31:0]} * {32'd0, PCT_RECIP};
    assign pct_quo  = 32'(pct_prod >> PCT_SHIFT);

    // recurrence operands: 2*delay + remainder over 4*count + 1
    assign num_s   = {sd_reg[31], sd_reg, 1'b0} + {{2{rem_reg[31]}}, rem_reg};
    assign num_neg = num_s[33];
    assign num_mag = num_neg ? (34'd0 - num_s) : num_s;
    assign den_s   = {rc_reg[29:0], 2'b01};
    assign den_neg = den_s[31];
    assign den_mag = den_neg ? (32'd0 - den_s) : den_s;

    // divider operands
    always_comb begin
        case (cmd.op)
            DP_MIND: begin
                div_dividend = {32'd0, min_delay_scale_reg};
                div_divisor  = {16'd0, spd};
            end
            DP_SQDIV: begin
                div_dividend = {32'd0, accel_sqrt_scale_reg};
                div_divisor  = {16'd0, acc};
            end
            DP_TDIV: begin
                div_dividend = {16'd0, prod_reg};
                div_divisor  = den_reg;
            end
            DP_LDIV: begin
                div_dividend = {16'd0, prod_reg};
                div_divisor  = {15'd0, ({1'b0, acc} + {1'b0, dec})};
            end
            DP_CDIV: begin
                div_dividend = {16'd0, prod_reg};
                div_divisor  = {16'd0, dec};
            end
            DP_RDIV: begin
                div_dividend = {30'd0, num_mag};
                div_divisor  = den_mag;
            end
            default: begin
                div_dividend = '0;
                div_divisor  = 32'd1;
            end
        endcase
    end

    slrp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    slrp_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (sqin_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // signed truncating quotient and remainder of the recurrence
    assign q32      = (num_neg ^ den_neg) ? (32'd0 - div_quo[31:0]) : div_quo[31:0];
    assign r32      = num_neg ? (32'd0 - div_rem) : div_rem;
    assign rec_next = sd_reg - q32;

    // deceleration count candidates, zero becomes minus one
    assign dc_lim = ((lim_reg - mag_reg) == 32'd0) ? '1 : (lim_reg - mag_reg);
    assign dc_quo = (div_quo[31:0] == 32'd0) ? '1 : (32'd0 - div_quo[31:0]);

    assign steps_inc = steps_reg + 32'd1;
    assign rc_inc    = rc_reg + 32'd1;
    assign out_free  = !m_valid_reg || m_ready;

    // micro-operation execution
    always_comb begin
        phase_next   = phase_reg;
        dir_next     = dir_reg;
        busy_next    = busy_reg;
        pos_next     = pos_reg;
        sd_next      = sd_reg;
        mind_next    = mind_reg;
        rc_next      = rc_reg;
        dss_next     = dss_reg;
        dc_next      = dc_reg;
        steps_next   = steps_reg;
        rem_next     = rem_reg;
        lad_next     = lad_reg;
        in_op_next   = in_op_reg;
        tgt_next     = tgt_reg;
        shown_next   = shown_reg;
        pulse_next   = pulse_reg;
        taken_next   = taken_reg;
        mag_next     = mag_reg;
        sqin_next    = sqin_reg;
        root_next    = root_reg;
        prod_next    = prod_reg;
        den_next     = den_reg;
        top_next     = top_reg;
        lim_next     = lim_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (cmd.op)
            DP_LOAD: begin
                in_op_next = s_data.op;
                tgt_next   = s_data.target_position;
                shown_next = sd_reg;
                pulse_next = 1'b0;
                taken_next = 1'b0;
            end
            DP_PLAN0: begin
                dir_next   = diff[31];
                mag_next   = diff_mag;
                busy_next  = (diff_mag != 32'd0);
                taken_next = 1'b1;
                if (diff_mag == 32'd1) begin
                    rc_next    = '1;
                    phase_next = PH_DECEL;
                    sd_next    = ONE_STEP_DELAY;
                end
            end
            DP_MIND:  if (div_done) mind_next = div_quo[31:0];
            DP_SQDIV: if (div_done) sqin_next = div_quo[31:0];
            DP_SQRT:  if (sqrt_done) root_next = sqrt_root;
            DP_FDIV:  sd_next = pct_quo;
            DP_DDIV:  den_next = pct_quo;
            DP_TDIV: begin
                if (den_reg == 32'd0) begin
                    top_next = '1;
                end else if (div_done) begin
                    top_next = (div_quo[31:0] == 32'd0) ? 32'd1 : div_quo[31:0];
                end
            end
            DP_LDIV: begin
                if (div_done) begin
                    lim_next = (div_quo[31:0] == 32'd0) ? 32'd1 : div_quo[31:0];
                end
            end
            DP_MUL1, DP_MUL2, DP_MUL3, DP_MUL4, DP_MUL5: begin
                prod_next = mul_full[47:0];
            end
            DP_DCLIM: dc_next = dc_lim;
            DP_CDIV:  if (div_done) dc_next = dc_quo;
            DP_FIN: begin
                dss_next = mag_reg + dc_reg;
                rc_next  = '0;
                if ($signed(sd_reg) <= $signed(mind_reg)) begin
                    sd_next    = mind_reg;
                    phase_next = PH_RUN;
                end else begin
                    phase_next = PH_ACCEL;
                end
            end
            DP_TICK0: begin
                if (phase_reg == PH_STOP) begin
                    steps_next = '0;
                    rem_next   = '0;
                    busy_next  = 1'b0;
                end else begin
                    pos_next   = dir_reg ? (pos_reg - 32'd1) : (pos_reg + 32'd1);
                    pulse_next = 1'b1;
                    steps_next = steps_inc;
                    if (phase_reg == PH_RUN) begin
                        if (steps_inc >= dss_reg) begin
                            rc_next    = dc_reg;
                            sd_next    = lad_reg;
                            phase_next = PH_DECEL;
                        end else begin
                            sd_next = mind_reg;
                        end
                    end else begin
                        rc_next = rc_inc;
                    end
                end
            end
            DP_RDIV: begin
                if (div_done) begin
                    sd_next  = rec_next;
                    rem_next = r32;
                    if (phase_reg == PH_ACCEL) begin
                        if (steps_reg >= dss_reg) begin
                            rc_next    = dc_reg;
                            phase_next = PH_DECEL;
                        end else if ($signed(rec_next) <= $signed(mind_reg)) begin
                            lad_next   = rec_next;
                            sd_next    = mind_reg;
                            rem_next   = '0;
                            phase_next = PH_RUN;
                        end
                    end else if (!rc_reg[31]) begin
                        phase_next = PH_STOP;
                    end
                end
            end
            DP_OUT: begin
                m_valid_next               = 1'b1;
                m_data_next.step_pulse     = pulse_reg;
                m_data_next.move_direction = dir_reg;
                m_data_next.timer_match    = (in_op_reg == OP_TICK) ?
                    (shown_reg[31] ? 32'd0 : shown_reg) : (sd_reg[31] ? 32'd0 : sd_reg);
                m_data_next.busy_res       = busy_reg;
                m_data_next.ramp_phase     = phase_reg;
                m_data_next.position       = pos_reg;
                m_data_next.command_taken  = taken_reg;
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_rate_reg        <= RST_ACCEL_RATE;
            decel_rate_reg        <= RST_DECEL_RATE;
            max_speed_reg         <= RST_MAX_SPEED;
            min_delay_scale_reg   <= RST_MIN_DELAY_SCALE;
            first_delay_scale_reg <= RST_FIRST_DELAY_SCALE;
            accel_sqrt_scale_reg  <= RST_ACCEL_SQRT_SCALE;
            ramp_length_scale_reg <= RST_RAMP_LENGTH_SCALE;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ACCEL_RATE:        accel_rate_reg        <= cfg_wdata[15:0];
                REG_DECEL_RATE:        decel_rate_reg        <= cfg_wdata[15:0];
                REG_MAX_SPEED:         max_speed_reg         <= cfg_wdata[15:0];
                REG_MIN_DELAY_SCALE:   min_delay_scale_reg   <= cfg_wdata;
                REG_FIRST_DELAY_SCALE: first_delay_scale_reg <= cfg_wdata[15:0];
                REG_ACCEL_SQRT_SCALE:  accel_sqrt_scale_reg  <= cfg_wdata;
                REG_RAMP_LENGTH_SCALE: ramp_length_scale_reg <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // move state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_STOP;
            dir_reg     <= 1'b0;
            busy_reg    <= 1'b0;
            pos_reg     <= '0;
            sd_reg      <= '0;
            mind_reg    <= '0;
            rc_reg      <= '0;
            dss_reg     <= '0;
            dc_reg      <= '0;
            steps_reg   <= '0;
            rem_reg     <= '0;
            lad_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            dir_reg     <= dir_next;
            busy_reg    <= busy_next;
            pos_reg     <= pos_next;
            sd_reg      <= sd_next;
            mind_reg    <= mind_next;
            rc_reg      <= rc_next;
            dss_reg     <= dss_next;
            dc_reg      <= dc_next;
            steps_reg   <= steps_next;
            rem_reg     <= rem_next;
            lad_reg     <= lad_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working values and result payload
    always_ff @(posedge aclk) begin
        in_op_reg  <= in_op_next;
        tgt_reg    <= tgt_next;
        shown_reg  <= shown_next;
        pulse_reg  <= pulse_next;
        taken_reg  <= taken_next;
        mag_reg    <= mag_next;
        sqin_reg   <= sqin_next;
        root_reg   <= root_next;
        prod_reg   <= prod_next;
        den_reg    <= den_next;
        top_reg    <= top_next;
        lim_reg    <= lim_next;
        m_data_reg <= m_data_next;
    end

    // status to controller
    always_comb begin
        status.busy       = busy_reg;
        status.in_op      = in_op_reg;
        status.short_move = (diff_mag <= 32'd1);
        status.phase      = phase_reg;
        status.div_done   = div_done;
        status.sqrt_done  = sqrt_done;
        status.den_zero   = (den_reg == 32'd0);
        status.lim_le_top = (lim_reg <= top_reg);
        status.out_free   = out_free;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/core/slrp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrp_ctrl: sequencing state machine of the ramp planner
// Walks the planning and tick sequences and issues datapath operations.
// ----------------------------------------------------------------------------
module slrp_ctrl
    import slrp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        issued_reg, issued_next;
    logic        div_state;

    // states that run the shared divider
    always_comb begin
        case (state_reg)
            ST_MIND, ST_SQDIV, ST_LDIV, ST_CDIV, ST_RDIV:
                div_state = 1'b1;
            ST_TDIV:  div_state = !status.den_zero;
            default:  div_state = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_DECODE;
            ST_DECODE: begin
                if (status.in_op == OP_MOVE) begin
                    state_next = status.busy ? ST_OUT : ST_PLAN0;
                end else begin
                    state_next = status.busy ? ST_TICK0 : ST_OUT;
                end
            end
            ST_PLAN0:  state_next = status.short_move ? ST_OUT : ST_MIND;
            ST_MIND:   if (status.div_done) state_next = ST_SQDIV;
            ST_SQDIV:  if (status.div_done) state_next = ST_SQRT;
            ST_SQRT:   if (status.sqrt_done) state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_FDIV;
            ST_FDIV:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_DDIV;
            ST_DDIV:   state_next = ST_MUL3;
            ST_MUL3:   state_next = ST_TDIV;
            ST_TDIV:   if (status.div_done || status.den_zero) state_next = ST_MUL4;
            ST_MUL4:   state_next = ST_LDIV;
            ST_LDIV:   if (status.div_done) state_next = ST_CHK;
            ST_CHK:    state_next = status.lim_le_top ? ST_FIN : ST_MUL5;
            ST_MUL5:   state_next = ST_CDIV;
            ST_CDIV:   if (status.div_done) state_next = ST_FIN;
            ST_FIN:    state_next = ST_OUT;
            ST_TICK0: begin
                if (status.phase == PH_ACCEL || status.phase == PH_DECEL) begin
                    state_next = ST_RDIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_RDIV:   if (status.div_done) state_next = ST_OUT;
            ST_OUT:    if (status.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd.div_start  = div_state && !issued_reg;
        cmd.sqrt_start = (state_reg == ST_SQRT) && !issued_reg;
        s_ready        = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:  cmd.op = s_valid ? DP_LOAD : DP_NOP;
            ST_PLAN0: cmd.op = DP_PLAN0;
            ST_MIND:  cmd.op = DP_MIND;
            ST_SQDIV: cmd.op = DP_SQDIV;
            ST_SQRT:  cmd.op = DP_SQRT;
            ST_MUL1:  cmd.op = DP_MUL1;
            ST_FDIV:  cmd.op = DP_FDIV;
            ST_MUL2:  cmd.op = DP_MUL2;
            ST_DDIV:  cmd.op = DP_DDIV;
            ST_MUL3:  cmd.op = DP_MUL3;
            ST_TDIV:  cmd.op = DP_TDIV;
            ST_MUL4:  cmd.op = DP_MUL4;
            ST_LDIV:  cmd.op = DP_LDIV;
            ST_CHK:   cmd.op = status.lim_le_top ? DP_DCLIM : DP_NOP;
            ST_MUL5:  cmd.op = DP_MUL5;
            ST_CDIV:  cmd.op = DP_CDIV;
            ST_FIN:   cmd.op = DP_FIN;
            ST_TICK0: cmd.op = DP_TICK0;
            ST_RDIV:  cmd.op = DP_RDIV;
            ST_OUT:   cmd.op = status.out_free ? DP_OUT : DP_NOP;
            default:  cmd.op = DP_NOP;
        endcase
    end

    // one start per divide or root step
    always_comb begin
        issued_next = issued_reg;
        if (status.div_done || status.sqrt_done) begin
            issued_next = 1'b0;
        end else if (cmd.div_start || cmd.sqrt_start) begin
            issued_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

endmodule

// File: rtl/core/stepper_linear_ramp_planner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_linear_ramp_planner: trapezoidal stepper move planner
// Plans a move on a move-to command and steps through accelerate, run and
// decelerate on each timer tick, one result per transaction.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   in_item_t  (op, target_position)
//  m_        out        m_valid / m_ready   out_item_t (step, dir, delay, ...)
//  cfg_      in         cfg_we              cfg_index, cfg_wdata
//
//  A planned move runs up to five divider passes and one root pass; the
//  two divides by 100 use the reciprocal multiply instead of the divider.
//  A tick in accelerate or decelerate runs one divider pass, and no other
//  transaction uses the divider.
//  One transaction is in work at a time; s_ready is high only when idle.
//  Synchronous active-low reset; no clearing pass. A stalled m_ready holds
//  the result and delays only the end of the next transaction.
// ----------------------------------------------------------------------------
module stepper_linear_ramp_planner
    import slrp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    slrp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    slrp_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // divider and root never started together
    a_single_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.div_start && cmd.sqrt_start))
        else $error("divider and root started in the same cycle");

    // an accepted transaction closes the input until its result is out
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a transaction is in work");

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_OUT) |-> (!m_valid || m_ready))
        else $error("result register overwritten");

    // a step only comes from a tick during a move
    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.step_pulse && (m_data.command_taken || !m_data.busy_res)))
        else $error("step pulse outside a running move");

endmodule
